[rtl/pngunf_pkg.sv]
`default_nettype none

package pngunf_pkg;

  localparam int unsigned LINE_BYTES_DEF = 8192;
  localparam int unsigned MAX_DIST_DEF   = 8;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned CFG_W      = 14;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned DIST_W     = 4;
  localparam int unsigned DIST_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST   = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH,
    FILT_BAD
  } filter_e;

  typedef struct packed {
    logic [7:0]            data;
    filter_e               filter;
    logic                  first_row;
    logic                  last;
    logic                  left_ok;
    logic [DIST_IDX_W-1:0] dist_idx;
  } entry_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] sa, sb, sc;
    logic signed [10:0] da, db, dc;
    logic [7:0] res;
    sa = 11'(signed'({3'b000, a}));
    sb = 11'(signed'({3'b000, b}));
    sc = 11'(signed'({3'b000, c}));
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) begin
      res = a;
    end else if (db <= dc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/png_scanline_unfilter.sv]
`default_nettype none

// PNG scanline unfilter: takes the inflated stream one byte per transfer and
// returns each reconstructed image byte (None, Sub, Up, Average, Paeth), with
// line_end on the last byte of a line and filter_error on every byte of a line
// whose filter type was above 4 (rebuilt as None). Filter type bytes give no
// output. Sustained rate is one byte per cycle unless the output stalls; data
// bytes pass the queue, stage-1 and output registers. The rate is set by the
// single write port and single registered read port of the previous-line RAM,
// which is read once and written once per byte. A small queue decouples the
// line tracker from the reconstruction stage, and an output register lets the
// next byte enter while a result waits. The previous-line RAM needs no clearing
// after reset. The user must write stride and filter distance through cfg
// (index 0 and 1) only while the block is idle; the block does not enforce it.

module png_scanline_unfilter #(
  parameter int unsigned LINE_BYTES   = pngunf_pkg::LINE_BYTES_DEF,
  parameter int unsigned MAX_DISTANCE = pngunf_pkg::MAX_DIST_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pngunf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pngunf_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [7:0]                          byte_in_i,
  input  wire logic                                frame_start_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [7:0]                          pixel_byte_o,
  output logic                                     line_end_o,
  output logic                                     filter_error_o
);

  localparam int unsigned AW = LINE_BYTES > 1 ? $clog2(LINE_BYTES) : 1;
  localparam int unsigned EW = $bits(pngunf_pkg::entry_t);
  localparam int unsigned QW = EW + AW;

  logic [pngunf_pkg::CFG_W-1:0]  stride_q;
  logic [pngunf_pkg::DIST_W-1:0] dist_q;

  logic               q_push, q_full, q_pop, q_valid;
  pngunf_pkg::entry_t f_entry, b_entry;
  logic [AW-1:0]      f_col, b_col;
  logic [QW-1:0]      q_din, q_dout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= pngunf_pkg::CFG_W'(1);
      dist_q   <= pngunf_pkg::DIST_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pngunf_pkg::CFG_STRIDE: stride_q <= cfg_data_i;
        pngunf_pkg::CFG_DIST:   dist_q   <= cfg_data_i[pngunf_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  pngunf_front #(
    .LINE_BYTES   (LINE_BYTES),
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .frame_start_i (frame_start_i),
    .stride_i      (stride_q),
    .dist_i        (dist_q),
    .full_i        (q_full),
    .push_o        (q_push),
    .entry_o       (f_entry),
    .col_o         (f_col)
  );

  assign q_din = {f_col, f_entry};

  pngunf_queue #(
    .WIDTH (QW),
    .DEPTH (pngunf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .valid_o (q_valid)
  );

  assign b_entry = pngunf_pkg::entry_t'(q_dout[EW-1:0]);
  assign b_col   = q_dout[QW-1:EW];

  pngunf_back #(
    .LINE_BYTES   (LINE_BYTES),
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .entry_i        (b_entry),
    .col_i          (b_col),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_byte_o   (pixel_byte_o),
    .line_end_o     (line_end_o),
    .filter_error_o (filter_error_o)
  );

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && !q_valid))
    else $error("queue pop while empty");

  a_type_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && frame_start_i) |-> !q_push)
    else $error("frame start byte entered the queue");
`endif

endmodule

`default_nettype wire

[rtl/pngunf_ram.sv]
`default_nettype none

module pngunf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/pngunf_queue.sv]
`default_nettype none

module pngunf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] din_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] dout_o,
  output logic                  valid_o
);

  localparam int unsigned PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = count_q == CW'(DEPTH);
  assign valid_o = count_q != '0;
  assign dout_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

`default_nettype wire

[rtl/pngunf_front.sv]
`default_nettype none

module pngunf_front #(
  parameter int unsigned LINE_BYTES   = pngunf_pkg::LINE_BYTES_DEF,
  parameter int unsigned MAX_DISTANCE = pngunf_pkg::MAX_DIST_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [7:0]                           byte_in_i,
  input  wire logic                                 frame_start_i,
  input  wire logic [pngunf_pkg::CFG_W-1:0]         stride_i,
  input  wire logic [pngunf_pkg::DIST_W-1:0]        dist_i,
  input  wire logic                                 full_i,
  output logic                                      push_o,
  output pngunf_pkg::entry_t                        entry_o,
  output logic [(LINE_BYTES > 1 ? $clog2(LINE_BYTES) : 1)-1:0] col_o
);

  localparam int unsigned AW = LINE_BYTES > 1 ? $clog2(LINE_BYTES) : 1;
  localparam int unsigned CW = $clog2(LINE_BYTES + 1);
  localparam int unsigned SW = CW > pngunf_pkg::CFG_W ? CW : pngunf_pkg::CFG_W;
  localparam int unsigned XW = CW > pngunf_pkg::DIST_W ? CW : pngunf_pkg::DIST_W;

  logic [CW-1:0]         column_q, column_d;
  pngunf_pkg::filter_e   filter_q, filter_d;
  logic                  first_row_q, first_row_d;
  logic                  awaiting_q, awaiting_d;

  logic                  accept;
  logic                  type_byte;
  logic [SW-1:0]         stride_w, stride_eff;
  logic [pngunf_pkg::DIST_W-1:0] dist_eff;
  logic [CW-1:0]         col_next;
  logic                  last;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign type_byte  = frame_start_i || awaiting_q;

  always_comb begin
    stride_w = SW'(stride_i);
    if (stride_w == '0) begin
      stride_eff = SW'(1);
    end else if (stride_w > SW'(LINE_BYTES)) begin
      stride_eff = SW'(LINE_BYTES);
    end else begin
      stride_eff = stride_w;
    end
    if (dist_i == '0) begin
      dist_eff = pngunf_pkg::DIST_W'(1);
    end else if (dist_i > pngunf_pkg::DIST_W'(MAX_DISTANCE)) begin
      dist_eff = pngunf_pkg::DIST_W'(MAX_DISTANCE);
    end else begin
      dist_eff = dist_i;
    end
  end

  assign col_next = column_q + 1'b1;
  assign last     = SW'(col_next) >= stride_eff;

  always_comb begin
    entry_o.data      = byte_in_i;
    entry_o.filter    = filter_q;
    entry_o.first_row = first_row_q;
    entry_o.last      = last;
    entry_o.left_ok   = XW'(column_q) >= XW'(dist_eff);
    entry_o.dist_idx  = pngunf_pkg::DIST_IDX_W'(dist_eff - 1'b1);
  end

  assign col_o  = column_q[AW-1:0];
  assign push_o = accept && !type_byte;

  always_comb begin
    column_d    = column_q;
    filter_d    = filter_q;
    first_row_d = first_row_q;
    awaiting_d  = awaiting_q;
    if (accept && type_byte) begin
      filter_d    = (byte_in_i > 8'd4) ? pngunf_pkg::FILT_BAD
                                       : pngunf_pkg::filter_e'(byte_in_i[2:0]);
      awaiting_d  = 1'b0;
      column_d    = '0;
      first_row_d = frame_start_i ? 1'b1 : first_row_q;
    end else if (accept) begin
      if (last) begin
        column_d    = '0;
        first_row_d = 1'b0;
        awaiting_d  = 1'b1;
      end else begin
        column_d = col_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      filter_q    <= pngunf_pkg::FILT_NONE;
      first_row_q <= 1'b1;
      awaiting_q  <= 1'b1;
    end else begin
      column_q    <= column_d;
      filter_q    <= filter_d;
      first_row_q <= first_row_d;
      awaiting_q  <= awaiting_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pngunf_back.sv]
`default_nettype none

module pngunf_back #(
  parameter int unsigned LINE_BYTES   = pngunf_pkg::LINE_BYTES_DEF,
  parameter int unsigned MAX_DISTANCE = pngunf_pkg::MAX_DIST_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  input  wire pngunf_pkg::entry_t                   entry_i,
  input  wire logic [(LINE_BYTES > 1 ? $clog2(LINE_BYTES) : 1)-1:0] col_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic      [7:0]                           pixel_byte_o,
  output logic                                      line_end_o,
  output logic                                      filter_error_o
);

  localparam int unsigned AW = LINE_BYTES > 1 ? $clog2(LINE_BYTES) : 1;
  localparam int unsigned DI = MAX_DISTANCE > 1 ? $clog2(MAX_DISTANCE) : 1;

  logic               s1_valid_q;
  pngunf_pkg::entry_t s1_entry_q;
  logic [AW-1:0]      s1_col_q;
  logic               fwd_q;
  logic [7:0]         fwd_data_q;
  logic [7:0]         left_q  [MAX_DISTANCE];
  logic [7:0]         upper_q [MAX_DISTANCE];
  logic               out_valid_q;

  logic               adv, load;
  logic [7:0]         ram_rdata;
  logic [7:0]         a, b, c, pred, val;
  logic [8:0]         ab_sum;
  logic [DI-1:0]      hidx;

  assign adv   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign load  = valid_i && (!s1_valid_q || adv);
  assign pop_o = load;

  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_above (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (s1_col_q),
    .wdata_i (val),
    .re_i    (load),
    .raddr_i (col_i),
    .rdata_o (ram_rdata)
  );

  assign hidx = s1_entry_q.dist_idx[DI-1:0];

  always_comb begin
    b = s1_entry_q.first_row ? 8'd0 : (fwd_q ? fwd_data_q : ram_rdata);
    a = s1_entry_q.left_ok ? left_q[hidx] : 8'd0;
    c = (s1_entry_q.left_ok && !s1_entry_q.first_row) ? upper_q[hidx] : 8'd0;
    ab_sum = {1'b0, a} + {1'b0, b};
    case (s1_entry_q.filter)
      pngunf_pkg::FILT_SUB:   pred = a;
      pngunf_pkg::FILT_UP:    pred = b;
      pngunf_pkg::FILT_AVG:   pred = ab_sum[8:1];
      pngunf_pkg::FILT_PAETH: pred = pngunf_pkg::paeth(a, b, c);
      default:                pred = 8'd0;
    endcase
    val = s1_entry_q.data + pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_entry_q <= entry_i;
      s1_col_q   <= col_i;
      fwd_q      <= adv && (s1_col_q == col_i);
      fwd_data_q <= val;
    end
    if (adv) begin
      for (int i = 1; i < int'(MAX_DISTANCE); i++) begin
        left_q[i]  <= left_q[i-1];
        upper_q[i] <= upper_q[i-1];
      end
      left_q[0]      <= val;
      upper_q[0]     <= b;
      pixel_byte_o   <= val;
      line_end_o     <= s1_entry_q.last;
      filter_error_o <= s1_entry_q.filter == pngunf_pkg::FILT_BAD;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
